FILE: sv/htpia_pkg.sv
package htpia_pkg;

  // ids handed out lie below ID_LIMIT; MAP_WORD_BITS must be a power of two
  localparam int ID_LIMIT      = 32768;
  localparam int MAP_WORD_BITS = 64;
  localparam int MAP_WORDS     = (ID_LIMIT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WORD_SHIFT    = $clog2(MAP_WORD_BITS);
  localparam int OFS_W         = (WORD_SHIFT > 0) ? WORD_SHIFT : 1;
  localparam int ADDR_W        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CHUNK_BITS    = (MAP_WORD_BITS >= 8) ? 8 : MAP_WORD_BITS;
  localparam int NUM_CHUNKS    = MAP_WORD_BITS / CHUNK_BITS;
  localparam int CH_W          = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
  localparam int BT_W          = (CHUNK_BITS > 1) ? $clog2(CHUNK_BITS) : 1;
  localparam int LAST_BITS     = ID_LIMIT - (MAP_WORDS - 1) * MAP_WORD_BITS;

  localparam logic [15:0] NO_ID = 16'hFFFF;

  typedef logic [MAP_WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_MARK    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NOFREE = 2'd1,
    STAT_RANGE  = 2'd2
  } stat_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_TEST,
    S_PICK,
    S_MODIFY,
    S_RESP
  } state_e;

endpackage

FILE: sv/hinted_two_pool_id_allocator.sv
// mark and release read, modify and write back one bitmap word; an id out of range goes
// straight to the response, as does an allocate with a parked hint; allocate reads and tests
// bitmap words from the hint upward, then picks the lowest free bit; clear rewrites every word
// one transaction at a time; the next is accepted from the cycle after the result loads
// reset: both hints go to zero and a clearing pass over all MAP_WORDS words (512 here)
// zeroes both bitmaps while input stall stays high
module hinted_two_pool_id_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic        pool_i,
  input  logic [15:0] id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] result_id_o,
  output logic [1:0]  status_o
);

  localparam int WB = htpia_pkg::MAP_WORD_BITS;
  localparam logic [htpia_pkg::ADDR_W-1:0] LAST_WORD =
    htpia_pkg::ADDR_W'(htpia_pkg::MAP_WORDS - 1);
  localparam htpia_pkg::word_t ALL_ONES  = {WB{1'b1}};
  localparam htpia_pkg::word_t LAST_MASK = ALL_ONES >> (WB - htpia_pkg::LAST_BITS);

  htpia_pkg::state_e state_q, state_d;
  htpia_pkg::op_e    op_q, op_d;
  logic              pool_q, pool_d;
  logic [15:0]       id_q, id_d;
  logic [htpia_pkg::ADDR_W-1:0] word_q, word_d;
  logic [htpia_pkg::OFS_W-1:0]  start_q, start_d;
  logic [htpia_pkg::ADDR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic              clr_resp_q, clr_resp_d;
  logic [15:0]       item_hint_q, item_hint_d;
  logic [15:0]       group_hint_q, group_hint_d;
  logic [15:0]       res_q, res_d;
  logic [1:0]        stat_q, stat_d;
  htpia_pkg::word_t  free_q, free_d;
  logic [htpia_pkg::NUM_CHUNKS-1:0] chunk_any_q, chunk_any_d;
  logic              out_valid_q, out_valid_d;
  logic [15:0]       out_id_q, out_id_d;
  logic [1:0]        out_stat_q, out_stat_d;

  htpia_pkg::word_t  item_mem [htpia_pkg::MAP_WORDS];
  htpia_pkg::word_t  group_mem [htpia_pkg::MAP_WORDS];
  htpia_pkg::word_t  item_rd_q, group_rd_q, rdata;

  logic              accept, out_load;
  logic              item_we, group_we;
  logic [htpia_pkg::ADDR_W-1:0] waddr;
  htpia_pkg::word_t  wdata;

  htpia_pkg::word_t  scan_free;
  logic [htpia_pkg::CH_W-1:0] pick_chunk;
  logic [htpia_pkg::BT_W-1:0] pick_bit;
  logic [htpia_pkg::CHUNK_BITS-1:0] pick_bits;
  logic [htpia_pkg::OFS_W-1:0] pick_pos, id_ofs;
  logic [15:0]       cand_id, cur_hint, bumped_hint;
  htpia_pkg::op_e    in_op;

  assign in_op    = htpia_pkg::op_e'(opcode_i);
  assign accept   = in_valid_i && !in_stall_o;
  assign out_load = (state_q == htpia_pkg::S_RESP) && (!out_valid_q || !out_stall_i);
  assign rdata    = pool_q ? group_rd_q : item_rd_q;
  assign id_ofs   = htpia_pkg::OFS_W'(id_q & 16'(WB - 1));

  // free candidates in the current word, bits below the start and past the limit masked
  always_comb begin
    scan_free = ~rdata & (ALL_ONES << start_q);
    if (word_q == LAST_WORD) begin
      scan_free = scan_free & LAST_MASK;
    end
  end

  // lowest free bit: lowest chunk with a free bit first, then lowest bit inside it
  always_comb begin
    pick_chunk = '0;
    for (int i = htpia_pkg::NUM_CHUNKS - 1; i >= 0; i--) begin
      if (chunk_any_q[i]) begin
        pick_chunk = htpia_pkg::CH_W'(i);
      end
    end
    pick_bits = htpia_pkg::CHUNK_BITS'(free_q >> (pick_chunk * htpia_pkg::CHUNK_BITS));
    pick_bit = '0;
    for (int j = htpia_pkg::CHUNK_BITS - 1; j >= 0; j--) begin
      if (pick_bits[j]) begin
        pick_bit = htpia_pkg::BT_W'(j);
      end
    end
    pick_pos = htpia_pkg::OFS_W'(pick_chunk * htpia_pkg::CHUNK_BITS + pick_bit);
    cand_id  = (16'(word_q) << htpia_pkg::WORD_SHIFT) | 16'(pick_pos);
  end

  assign cur_hint    = pool_i ? group_hint_q : item_hint_q;
  assign bumped_hint = (cur_hint == 16'd0) ? 16'd1 : cur_hint;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      htpia_pkg::S_CLEAR: begin
        if (clr_cnt_q == LAST_WORD) begin
          state_d = clr_resp_q ? htpia_pkg::S_RESP : htpia_pkg::S_IDLE;
        end
      end
      htpia_pkg::S_IDLE: begin
        if (accept) begin
          case (in_op)
            htpia_pkg::OP_ALLOC: begin
              state_d = (bumped_hint >= 16'(htpia_pkg::ID_LIMIT)) ?
                        htpia_pkg::S_RESP : htpia_pkg::S_READ;
            end
            htpia_pkg::OP_MARK, htpia_pkg::OP_RELEASE: begin
              state_d = (id_i < 16'(htpia_pkg::ID_LIMIT)) ?
                        htpia_pkg::S_READ : htpia_pkg::S_RESP;
            end
            default: state_d = htpia_pkg::S_CLEAR;
          endcase
        end
      end
      htpia_pkg::S_READ: begin
        state_d = (op_q == htpia_pkg::OP_ALLOC) ? htpia_pkg::S_TEST : htpia_pkg::S_MODIFY;
      end
      htpia_pkg::S_TEST: begin
        if (scan_free != '0) begin
          state_d = htpia_pkg::S_PICK;
        end else if (word_q == LAST_WORD) begin
          state_d = htpia_pkg::S_RESP;
        end else begin
          state_d = htpia_pkg::S_READ;
        end
      end
      htpia_pkg::S_PICK:   state_d = htpia_pkg::S_RESP;
      htpia_pkg::S_MODIFY: state_d = htpia_pkg::S_RESP;
      htpia_pkg::S_RESP: begin
        if (out_load) begin
          state_d = htpia_pkg::S_IDLE;
        end
      end
      default: state_d = htpia_pkg::S_IDLE;
    endcase
  end

  // outputs and memory write port
  always_comb begin
    in_stall_o = (state_q != htpia_pkg::S_IDLE);
    item_we    = 1'b0;
    group_we   = 1'b0;
    waddr      = word_q;
    wdata      = rdata;
    case (state_q)
      htpia_pkg::S_CLEAR: begin
        item_we  = 1'b1;
        group_we = 1'b1;
        waddr    = clr_cnt_q;
        wdata    = '0;
      end
      htpia_pkg::S_PICK: begin
        item_we  = !pool_q;
        group_we = pool_q;
        wdata    = rdata | (htpia_pkg::word_t'(1) << pick_pos);
      end
      htpia_pkg::S_MODIFY: begin
        item_we  = !pool_q;
        group_we = pool_q;
        if (op_q == htpia_pkg::OP_MARK) begin
          wdata = rdata | (htpia_pkg::word_t'(1) << id_ofs);
        end else begin
          wdata = rdata & ~(htpia_pkg::word_t'(1) << id_ofs);
        end
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    op_d         = op_q;
    pool_d       = pool_q;
    id_d         = id_q;
    word_d       = word_q;
    start_d      = start_q;
    clr_cnt_d    = clr_cnt_q;
    clr_resp_d   = clr_resp_q;
    item_hint_d  = item_hint_q;
    group_hint_d = group_hint_q;
    res_d        = res_q;
    stat_d       = stat_q;
    free_d       = free_q;
    chunk_any_d  = chunk_any_q;
    out_valid_d  = out_valid_q;
    out_id_d     = out_id_q;
    out_stat_d   = out_stat_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      out_id_d    = res_q;
      out_stat_d  = stat_q;
    end

    case (state_q)
      htpia_pkg::S_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
      end
      htpia_pkg::S_IDLE: begin
        if (accept) begin
          op_d   = in_op;
          pool_d = pool_i;
          id_d   = id_i;
          res_d  = id_i;
          stat_d = htpia_pkg::STAT_OK;
          case (in_op)
            htpia_pkg::OP_ALLOC: begin
              word_d  = htpia_pkg::ADDR_W'(bumped_hint >> htpia_pkg::WORD_SHIFT);
              start_d = htpia_pkg::OFS_W'(bumped_hint & 16'(WB - 1));
              if (bumped_hint >= 16'(htpia_pkg::ID_LIMIT)) begin
                res_d  = htpia_pkg::NO_ID;
                stat_d = htpia_pkg::STAT_NOFREE;
                if (pool_i) group_hint_d = htpia_pkg::NO_ID;
                else        item_hint_d  = htpia_pkg::NO_ID;
              end
            end
            htpia_pkg::OP_MARK, htpia_pkg::OP_RELEASE: begin
              word_d = htpia_pkg::ADDR_W'(id_i >> htpia_pkg::WORD_SHIFT);
              if (id_i >= 16'(htpia_pkg::ID_LIMIT)) begin
                stat_d = htpia_pkg::STAT_RANGE;
              end
              // release lowers the hint even when the id is out of range
              if (in_op == htpia_pkg::OP_RELEASE && cur_hint > id_i) begin
                if (pool_i) group_hint_d = id_i;
                else        item_hint_d  = id_i;
              end
            end
            default: begin
              item_hint_d  = '0;
              group_hint_d = '0;
              clr_cnt_d    = '0;
              clr_resp_d   = 1'b1;
            end
          endcase
        end
      end
      htpia_pkg::S_TEST: begin
        free_d = scan_free;
        for (int c = 0; c < htpia_pkg::NUM_CHUNKS; c++) begin
          chunk_any_d[c] = |scan_free[c*htpia_pkg::CHUNK_BITS +: htpia_pkg::CHUNK_BITS];
        end
        if (scan_free == '0) begin
          if (word_q == LAST_WORD) begin
            res_d  = htpia_pkg::NO_ID;
            stat_d = htpia_pkg::STAT_NOFREE;
            if (pool_q) group_hint_d = htpia_pkg::NO_ID;
            else        item_hint_d  = htpia_pkg::NO_ID;
          end else begin
            word_d  = word_q + 1'b1;
            start_d = '0;
          end
        end
      end
      htpia_pkg::S_PICK: begin
        res_d  = cand_id;
        stat_d = htpia_pkg::STAT_OK;
        if (pool_q) group_hint_d = cand_id + 16'd1;
        else        item_hint_d  = cand_id + 16'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= htpia_pkg::S_CLEAR;
      clr_cnt_q    <= '0;
      clr_resp_q   <= 1'b0;
      item_hint_q  <= '0;
      group_hint_q <= '0;
      out_valid_q  <= 1'b0;
      op_q         <= htpia_pkg::OP_ALLOC;
    end else begin
      state_q      <= state_d;
      clr_cnt_q    <= clr_cnt_d;
      clr_resp_q   <= (state_q == htpia_pkg::S_RESP) ? 1'b0 : clr_resp_d;
      item_hint_q  <= item_hint_d;
      group_hint_q <= group_hint_d;
      out_valid_q  <= out_valid_d;
      op_q         <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pool_q      <= pool_d;
    id_q        <= id_d;
    word_q      <= word_d;
    start_q     <= start_d;
    res_q       <= res_d;
    stat_q      <= stat_d;
    free_q      <= free_d;
    chunk_any_q <= chunk_any_d;
    out_id_q    <= out_id_d;
    out_stat_q  <= out_stat_d;
  end

  always_ff @(posedge clk_i) begin
    if (item_we) begin
      item_mem[waddr] <= wdata;
    end
    item_rd_q <= item_mem[word_q];
  end

  always_ff @(posedge clk_i) begin
    if (group_we) begin
      group_mem[waddr] <= wdata;
    end
    group_rd_q <= group_mem[word_q];
  end

  assign out_valid_o = out_valid_q;
  assign result_id_o = out_id_q;
  assign status_o    = out_stat_q;

  a_nofree_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == htpia_pkg::STAT_NOFREE |-> result_id_o == htpia_pkg::NO_ID)
    else $error("no-free status without the no-id result");

  a_pick_has_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == htpia_pkg::S_PICK |-> free_q != '0 && chunk_any_q != '0)
    else $error("pick entered with no free bit");

  a_pick_hint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == htpia_pkg::S_PICK |=> (pool_q ? group_hint_q : item_hint_q) == res_q + 16'd1)
    else $error("hint not moved past the allocated id");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_we || group_we) |-> state_q != htpia_pkg::S_IDLE && state_q != htpia_pkg::S_RESP)
    else $error("bitmap written outside an operation");

  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == htpia_pkg::S_CLEAR |-> in_stall_o && item_we && group_we)
    else $error("clearing pass not holding off input");

endmodule

FILE: bench/testbench.sv
module testbench;

  localparam logic POOL_ITEM    = 1'b0;
  localparam logic POOL_GROUP   = 1'b1;
  localparam int   RANDOM_ITEMS = 1080;
  localparam int   FILL_IDS     = 640;
  localparam int   STALL_LIMIT  = 20000;
  localparam int   HOLD_CYCLES  = 250;

  typedef struct packed {
    logic [15:0]       result_id;
    htpia_pkg::stat_e  status;
  } alloc_result_t;

  typedef struct packed {
    logic        pool;
    logic [15:0] id;
  } pool_id_t;

  // mirror of both pools; predicts one result per accepted transaction
  class id_pool_scoreboard;
    bit            used_map[2][htpia_pkg::ID_LIMIT];
    logic [15:0]   hint[2];
    alloc_result_t awaited_results[$];
    int            n_errors;
    int            n_checked;
    int            n_alloc_ok;
    int            n_nofree;
    int            n_range;

    function void wipe();
      foreach (used_map[p, i]) used_map[p][i] = 1'b0;
      hint[0] = '0;
      hint[1] = '0;
    endfunction

    function alloc_result_t note_request(htpia_pkg::op_e op, logic pool, logic [15:0] id);
      alloc_result_t res;
      int            cand;
      res.result_id = id;
      res.status    = htpia_pkg::STAT_OK;
      case (op)
        htpia_pkg::OP_ALLOC: begin
          if (hint[pool] == '0) hint[pool] = 16'd1;
          // a parked hint skips the scan entirely
          for (cand = hint[pool]; cand < htpia_pkg::ID_LIMIT && used_map[pool][cand];
               cand++) ;
          if (cand < htpia_pkg::ID_LIMIT) begin
            used_map[pool][cand] = 1'b1;
            res.result_id = cand[15:0];
            hint[pool]    = cand[15:0] + 16'd1;
            n_alloc_ok++;
          end else begin
            res.result_id = htpia_pkg::NO_ID;
            res.status    = htpia_pkg::STAT_NOFREE;
            hint[pool]    = htpia_pkg::NO_ID;
            n_nofree++;
          end
        end
        htpia_pkg::OP_MARK: begin
          if (id < htpia_pkg::ID_LIMIT) begin
            used_map[pool][id] = 1'b1;
          end else begin
            res.status = htpia_pkg::STAT_RANGE;
            n_range++;
          end
        end
        htpia_pkg::OP_RELEASE: begin
          if (id < htpia_pkg::ID_LIMIT) begin
            used_map[pool][id] = 1'b0;
          end else begin
            res.status = htpia_pkg::STAT_RANGE;
            n_range++;
          end
          // hint drops even for out-of-range ids
          if (hint[pool] > id) hint[pool] = id;
        end
        default: wipe();
      endcase
      awaited_results.push_back(res);
      return res;
    endfunction

    function void check_result(logic [15:0] result_id, logic [1:0] status);
      alloc_result_t exp_res;
      n_checked++;
      if (awaited_results.size() == 0) begin
        $error("unexpected result: result_id %0d, status %0d", result_id, status);
        n_errors++;
      end else begin
        exp_res = awaited_results.pop_front();
        if (result_id !== exp_res.result_id) begin
          $error("result_id mismatch: expected %0d, actual %0d", exp_res.result_id, result_id);
          n_errors++;
        end
        if (status !== exp_res.status) begin
          $error("status mismatch: expected %0d, actual %0d", exp_res.status, status);
          n_errors++;
        end
      end
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [1:0]  opcode_i    = htpia_pkg::OP_ALLOC;
  logic        pool_i      = POOL_ITEM;
  logic [15:0] id_i        = '0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [15:0] result_id_o;
  logic [1:0]  status_o;

  id_pool_scoreboard sb;
  alloc_result_t     last_pred;
  pool_id_t          live_q[$];
  bit                steady         = 1'b0;
  bit                pressure_armed = 1'b0;
  bit                pressure_done  = 1'b0;
  int                n_sent         = 0;

  always #10 clk_i = ~clk_i;

  hinted_two_pool_id_allocator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .pool_i      (pool_i),
    .id_i        (id_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_id_o (result_id_o),
    .status_o    (status_o)
  );

  task automatic issue(htpia_pkg::op_e op, logic pool, logic [15:0] id);
    while (!steady && $urandom_range(99) < 32) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    pool_i     <= pool;
    id_i       <= id;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    last_pred = sb.note_request(op, pool, id);
    n_sent++;
  endtask

  function automatic logic [15:0] pick_id();
    int s;
    s = $urandom_range(99);
    if (s < 55) return 16'($urandom_range(200));
    else if (s < 70) return 16'($urandom_range(htpia_pkg::ID_LIMIT + 40,
                                                 htpia_pkg::ID_LIMIT - 40));
    else if (s < 90) return 16'($urandom());
    else return {1'b0, 15'($urandom())};
  endfunction

  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_stall_i == 1'b0) sb.check_result(result_id_o, status_o);
      if (pressure_armed && !pressure_done) begin
        hold_left     = HOLD_CYCLES;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !steady && ($urandom_range(99) < 32);
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int       r;
    int       k;
    logic     pool;
    pool_id_t entry;
    sb = new();
    sb.wipe();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // hint walk, zero id, range edges, reuse after release
    issue(htpia_pkg::OP_ALLOC, POOL_ITEM, 16'h0000);
    issue(htpia_pkg::OP_ALLOC, POOL_ITEM, 16'hFFFF);
    issue(htpia_pkg::OP_MARK, POOL_ITEM, 16'h0000);
    issue(htpia_pkg::OP_MARK, POOL_ITEM, 16'h0003);
    issue(htpia_pkg::OP_ALLOC, POOL_ITEM, 16'h0000);
    issue(htpia_pkg::OP_MARK, POOL_ITEM, 16'(htpia_pkg::ID_LIMIT - 1));
    issue(htpia_pkg::OP_MARK, POOL_ITEM, 16'(htpia_pkg::ID_LIMIT));
    issue(htpia_pkg::OP_MARK, POOL_ITEM, 16'hFFFF);
    issue(htpia_pkg::OP_RELEASE, POOL_ITEM, 16'h0002);
    issue(htpia_pkg::OP_ALLOC, POOL_ITEM, 16'h0000);
    issue(htpia_pkg::OP_RELEASE, POOL_ITEM, 16'h0000);
    issue(htpia_pkg::OP_ALLOC, POOL_ITEM, 16'h0000);
    issue(htpia_pkg::OP_RELEASE, POOL_ITEM, 16'd100);
    issue(htpia_pkg::OP_MARK, POOL_ITEM, 16'h0003);
    issue(htpia_pkg::OP_RELEASE, POOL_ITEM, 16'hFFFF);
    issue(htpia_pkg::OP_RELEASE, POOL_ITEM, 16'h8000);
    issue(htpia_pkg::OP_ALLOC, POOL_GROUP, 16'h0000);
    issue(htpia_pkg::OP_MARK, POOL_GROUP, 16'h5555);
    issue(htpia_pkg::OP_RELEASE, POOL_GROUP, 16'hAAAA);
    issue(htpia_pkg::OP_CLEAR, POOL_GROUP, 16'hFFFF);
    issue(htpia_pkg::OP_ALLOC, POOL_ITEM, 16'h0000);
    issue(htpia_pkg::OP_ALLOC, POOL_GROUP, 16'h0000);

    // mark a run of group ids so the following allocates scan across several words
    steady = 1'b1;
    for (int i = 1; i < FILL_IDS; i++) issue(htpia_pkg::OP_MARK, POOL_GROUP, 16'(i));
    issue(htpia_pkg::OP_ALLOC, POOL_GROUP, 16'h0000);
    issue(htpia_pkg::OP_ALLOC, POOL_GROUP, 16'h0000);
    issue(htpia_pkg::OP_RELEASE, POOL_GROUP, 16'hABCD);
    issue(htpia_pkg::OP_ALLOC, POOL_GROUP, 16'h0000);
    issue(htpia_pkg::OP_RELEASE, POOL_GROUP, 16'h0000);
    issue(htpia_pkg::OP_ALLOC, POOL_GROUP, 16'h0000);
    issue(htpia_pkg::OP_RELEASE, POOL_GROUP, 16'd12345);
    issue(htpia_pkg::OP_ALLOC, POOL_GROUP, 16'h0000);
    issue(htpia_pkg::OP_ALLOC, POOL_GROUP, 16'h0000);
    issue(htpia_pkg::OP_CLEAR, POOL_ITEM, 16'h0000);
    steady = 1'b0;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 700 && n < 1000);
      if (n == 200) pressure_armed = 1'b1;
      r    = $urandom_range(99);
      pool = 1'($urandom());
      if (r < 40) begin
        issue(htpia_pkg::OP_ALLOC, pool, 16'($urandom()));
        if (last_pred.status == htpia_pkg::STAT_OK)
          live_q.push_back({pool, last_pred.result_id});
      end else if (r < 55) begin
        issue(htpia_pkg::OP_MARK, pool, pick_id());
      end else if (r < 72 && live_q.size() != 0) begin
        // give back an id the block handed out earlier
        k     = $urandom_range(live_q.size() - 1);
        entry = live_q[k];
        live_q.delete(k);
        issue(htpia_pkg::OP_RELEASE, entry.pool, entry.id);
      end else if (r < 98) begin
        issue(htpia_pkg::OP_RELEASE, pool, pick_id());
      end else begin
        issue(htpia_pkg::OP_CLEAR, pool, pick_id());
        live_q.delete();
      end
    end
    in_valid_i <= 1'b0;

    while (sb.awaited_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.awaited_results.size() != 0) begin
      $error("%0d expected results never arrived", sb.awaited_results.size());
      sb.n_errors++;
    end
    $display("sent %0d transactions, checked %0d results", n_sent, sb.n_checked);
    $display("ids allocated %0d, pool exhausted %0d, out of range %0d, mismatches %0d",
             sb.n_alloc_ok, sb.n_nofree, sb.n_range, sb.n_errors);
    if (sb.n_errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: files.f
sv/htpia_pkg.sv
sv/hinted_two_pool_id_allocator.sv
bench/testbench.sv
